[rtl/ack_wait_retry_controller_top_macros.svh]
// Assertion helpers for the stop-and-wait sender.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ACK_WAIT_RETRY_CONTROLLER_TOP_MACROS_SVH
`define ACK_WAIT_RETRY_CONTROLLER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is high.
`define AWR_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("awr check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define AWR_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("awr check failed: next-cycle implication");

`else

`define AWR_ASSERT_IMP(name, clk, rst, ante, cons)
`define AWR_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

[rtl/awr_pkg.sv]
package awr_pkg;

  // Event codes carried in the mode field.
  localparam logic [2:0] MODE_SEND      = 3'd0;
  localparam logic [2:0] MODE_TICK      = 3'd1;
  localparam logic [2:0] MODE_ACK       = 3'd2;
  localparam logic [2:0] MODE_NACK      = 3'd3;
  localparam logic [2:0] MODE_UNSUP     = 3'd4;
  localparam logic [2:0] MODE_BULK_BUSY = 3'd5;
  localparam logic [2:0] MODE_BULK_IDLE = 3'd6;

  // Result action codes.
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_TX      = 3'd1;
  localparam logic [2:0] ACT_BULK    = 3'd2;
  localparam logic [2:0] ACT_REJECT  = 3'd3;
  localparam logic [2:0] ACT_RETX    = 3'd4;
  localparam logic [2:0] ACT_DONE    = 3'd5;
  localparam logic [2:0] ACT_REFUSED = 3'd6;
  localparam logic [2:0] ACT_UNREACH = 3'd7;

  // Configuration register indexes.
  localparam logic [1:0] CFG_HEADER_AIRTIME    = 2'd0;
  localparam logic [1:0] CFG_BYTE_AIRTIME      = 2'd1;
  localparam logic [1:0] CFG_PROCESS_ALLOWANCE = 2'd2;

  // Protocol constants.
  localparam logic [3:0]  RETRY_LIMIT      = 4'd3;
  localparam logic [11:0] DIRECT_MAX_BYTES = 12'd255;
  localparam logic [11:0] BUFFER_BYTES     = 12'd2048;
  localparam logic [4:0]  ACK_BYTES        = 5'd4;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_BULK = 2'd2
  } phase_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] now;
    logic        link_ready;
    logic        bulk_engine_busy;
    logic [11:0] message_length;
    logic [7:0]  message_id;
    logic        notify;
  } item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  report_id;
    logic [11:0] send_length;
    logic        busy_res;
  } result_t;

  typedef struct packed {
    logic [15:0] header_airtime;
    logic [15:0] byte_airtime;
    logic [15:0] process_allowance;
  } cfg_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] retries_left;
  } status_t;

endpackage

[rtl/awr_in_reg.sv]
module awr_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  awr_pkg::item_t item_d,
  input  logic           take,
  output logic           hold_valid,
  output awr_pkg::item_t item_q
);

  import awr_pkg::*;

  logic accept;

  assign in_ready = !hold_valid || take;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

[rtl/awr_ctrl.sv]
module awr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  awr_pkg::item_t   item,
  input  awr_pkg::cfg_t    cfg,
  output awr_pkg::result_t res,
  output awr_pkg::status_t stat
);

  import awr_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] sent_time, sent_time_next;
  logic [31:0] wait_limit, wait_limit_next;
  logic [3:0]  retries_left, retries_left_next;
  logic [7:0]  held_id, held_id_next;
  logic [11:0] held_length, held_length_next;
  logic        held_notify, held_notify_next;

  logic        send_ok;
  logic        is_direct;
  logic        expired;
  logic        in_wait;
  logic [31:0] elapsed;
  logic [12:0] len_ack;
  logic [28:0] byte_product;
  logic [31:0] limit_calc;

  assign in_wait   = (phase == PH_WAIT);
  assign send_ok   = item.link_ready && !item.bulk_engine_busy && (phase == PH_IDLE)
                     && (item.message_length <= BUFFER_BYTES);
  assign is_direct = (item.message_length <= DIRECT_MAX_BYTES);
  assign elapsed   = item.now - sent_time;
  assign expired   = (elapsed > wait_limit);

  // Wait limit: two header airtimes, bytes of message plus ack, and the allowance.
  assign len_ack      = {1'b0, item.message_length} + {8'd0, ACK_BYTES};
  assign byte_product = {13'd0, cfg.byte_airtime} * {16'd0, len_ack};
  assign limit_calc   = {15'd0, cfg.header_airtime, 1'b0} + {3'd0, byte_product}
                        + {16'd0, cfg.process_allowance};

  always_comb begin
    phase_next        = phase;
    sent_time_next    = sent_time;
    wait_limit_next   = wait_limit;
    retries_left_next = retries_left;
    held_id_next      = held_id;
    held_length_next  = held_length;
    held_notify_next  = held_notify;
    if (step) begin
      case (item.mode)
        MODE_SEND: begin
          if (send_ok) begin
            held_id_next     = item.message_id;
            held_length_next = item.message_length;
            held_notify_next = item.notify;
            if (is_direct) begin
              wait_limit_next   = limit_calc;
              sent_time_next    = item.now;
              retries_left_next = RETRY_LIMIT;
              phase_next        = PH_WAIT;
            end
          end
        end
        MODE_TICK: begin
          if (in_wait && expired) begin
            if (retries_left != 4'd0) begin
              retries_left_next = retries_left - 4'd1;
              sent_time_next    = item.now;
            end else begin
              phase_next       = PH_IDLE;
              held_id_next     = '0;
              held_length_next = '0;
              held_notify_next = 1'b0;
            end
          end
        end
        MODE_ACK, MODE_NACK, MODE_UNSUP: begin
          if (in_wait) begin
            phase_next       = PH_IDLE;
            held_id_next     = '0;
            held_length_next = '0;
            held_notify_next = 1'b0;
          end
        end
        MODE_BULK_BUSY: begin
          if (phase == PH_IDLE) begin
            phase_next = PH_BULK;
          end
        end
        MODE_BULK_IDLE: begin
          if (phase == PH_BULK) begin
            phase_next       = PH_IDLE;
            held_id_next     = '0;
            held_length_next = '0;
            held_notify_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res = '{action: ACT_NONE, report_id: 8'd0, send_length: 12'd0,
            busy_res: (phase_next != PH_IDLE)};
    case (item.mode)
      MODE_SEND: begin
        res.report_id = item.message_id;
        if (!send_ok) begin
          res.action = ACT_REJECT;
        end else if (is_direct) begin
          res.action      = ACT_TX;
          res.send_length = item.message_length;
        end else begin
          res.action = ACT_BULK;
        end
      end
      MODE_TICK: begin
        if (in_wait && expired) begin
          if (retries_left != 4'd0) begin
            res.action      = ACT_RETX;
            res.report_id   = held_id;
            res.send_length = held_length;
          end else if (held_notify) begin
            res.action    = ACT_UNREACH;
            res.report_id = held_id;
          end
        end
      end
      MODE_ACK: begin
        if (in_wait && held_notify) begin
          res.action    = ACT_DONE;
          res.report_id = held_id;
        end
      end
      MODE_NACK, MODE_UNSUP: begin
        if (in_wait && held_notify) begin
          res.action    = ACT_REFUSED;
          res.report_id = held_id;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      sent_time    <= '0;
      wait_limit   <= '0;
      retries_left <= '0;
      held_id      <= '0;
      held_length  <= '0;
      held_notify  <= 1'b0;
    end else begin
      phase        <= phase_next;
      sent_time    <= sent_time_next;
      wait_limit   <= wait_limit_next;
      retries_left <= retries_left_next;
      held_id      <= held_id_next;
      held_length  <= held_length_next;
      held_notify  <= held_notify_next;
    end
  end

  assign stat = '{phase: phase, retries_left: retries_left};

endmodule

[rtl/awr_out_reg.sv]
module awr_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  awr_pkg::result_t res_d,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output awr_pkg::result_t res_q
);

  import awr_pkg::*;

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_d;
    end
  end

endmodule

[rtl/ack_wait_retry_controller_top.sv]
// Stop-and-wait sender controller.
// Input channel (in_valid/in_ready) carries one event per transfer: a send request,
// a timer tick, an ack, nack or unsupported answer, or a bulk engine busy/idle note.
// Every input transfer produces exactly one result transfer on the output channel
// (out_valid/out_ready) with the action, message id, length and busy flag.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the header airtime,
// byte airtime and processing allowance; cfg_ready is always high, and writes are
// expected only while no event is in flight. Writes to unused indexes are dropped.
// The event is captured in an input register, and the state update runs on it and
// lands its result in the result register. Throughput is one event per cycle while
// the receiver takes results; the only loop is the phase/timer state update, which
// holds one 16x13 multiply and a 32-bit compare.
// Reset (synchronous, active high) returns to idle, clears the timers, retry count,
// held message and configuration, and empties both registers.
// When the receiver stalls, the result register holds its item, the input register
// takes one more event, and in_ready then drops until the result is taken.
`include "ack_wait_retry_controller_top_macros.svh"

module ack_wait_retry_controller_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [31:0] now,
  input  logic        link_ready,
  input  logic        bulk_engine_busy,
  input  logic [11:0] message_length,
  input  logic [7:0]  message_id,
  input  logic        notify,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  action,
  output logic [7:0]  report_id,
  output logic [11:0] send_length,
  output logic        busy_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  import awr_pkg::*;

  item_t   item_d;
  item_t   item_q;
  logic    hold_valid;
  logic    step;
  logic    space;
  result_t res_d;
  result_t res_q;
  cfg_t    cfg;
  status_t ctrl_stat;

  // The configuration port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HEADER_AIRTIME:    cfg.header_airtime    <= cfg_data;
        CFG_BYTE_AIRTIME:      cfg.byte_airtime      <= cfg_data;
        CFG_PROCESS_ALLOWANCE: cfg.process_allowance <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign item_d = '{mode: mode, now: now, link_ready: link_ready,
                    bulk_engine_busy: bulk_engine_busy, message_length: message_length,
                    message_id: message_id, notify: notify};

  // An event moves from the input register into the state update whenever the
  // result register has room for its result in the same cycle.
  assign step = hold_valid && space;

  awr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item_d     (item_d),
    .take       (step),
    .hold_valid (hold_valid),
    .item_q     (item_q)
  );

  awr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item_q),
    .cfg  (cfg),
    .res  (res_d),
    .stat (ctrl_stat)
  );

  awr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res_d     (res_d),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_q     (res_q)
  );

  assign action      = res_q.action;
  assign report_id   = res_q.report_id;
  assign send_length = res_q.send_length;
  assign busy_res    = res_q.busy_res;

  // The retry counter is loaded with the limit and only ever counts down.
  `AWR_ASSERT_IMP(a_retry_bound, clk, rst, 1'b1, ctrl_stat.retries_left <= RETRY_LIMIT)

  // Every event that leaves the input register shows up as a result next cycle.
  `AWR_ASSERT_NXT(a_step_delivers, clk, rst, step, out_valid)

  // A transmit or retransmit always leaves the sender waiting.
  `AWR_ASSERT_IMP(a_tx_busy, clk, rst,
    out_valid && (action == ACT_TX || action == ACT_RETX), busy_res)

  // Completion reports always leave the sender idle.
  `AWR_ASSERT_IMP(a_finish_idle, clk, rst,
    out_valid && (action == ACT_DONE || action == ACT_REFUSED || action == ACT_UNREACH),
    !busy_res)

endmodule
